>>> hdl/mipsx_pkg.sv
// ----------------------------------------------------------------------------
// mipsx_pkg
// Shared types and constants of the integer execute block: opcodes,
// status codes and the structs that pass between the execute logic,
// the register file and the top level.
// ----------------------------------------------------------------------------
package mipsx_pkg;

  localparam int unsigned XLEN    = 32;
  localparam int unsigned GPR_AW  = 5;
  localparam int unsigned GPR_NUM = 1 << GPR_AW;

  localparam logic [XLEN-1:0] BOOT_RESET = 32'hBFC0_0000;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_SW      = 6'h2b;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_ADDU = 6'h21;

  localparam logic FUNC_INSTR = 1'b0;
  localparam logic FUNC_LOAD  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNIMPL   = 2'd1,
    ST_REJECTED = 2'd2,
    ST_HALTED   = 2'd3
  } status_t;

  typedef struct packed {
    logic [XLEN-1:0]   fetch_pc;
    logic [XLEN-1:0]   branch_target;
    logic              branch_pending;
    logic              load_pending;
    logic [GPR_AW-1:0] load_dest;
    logic              load_is_byte;
    logic              halted;
  } arch_t;

  typedef struct packed {
    logic              en;
    logic [GPR_AW-1:0] addr;
    logic [XLEN-1:0]   data;
  } gpr_wr_t;

  typedef struct packed {
    logic [XLEN-1:0] fetch_address;
    logic            mem_read;
    logic            mem_write;
    logic            mem_byte;
    logic [XLEN-1:0] mem_address;
    logic [XLEN-1:0] store_data;
    status_t         status;
  } result_t;

endpackage

>>> hdl/mipsx_regfile.sv
// ----------------------------------------------------------------------------
// mipsx_regfile
// General register file: a 32-entry memory with two registered read ports
// and one write port. Per-entry valid bits make unwritten registers read
// as zero after reset, and the most recent write is forwarded to reads
// that were launched in the same cycle as that write.
// ----------------------------------------------------------------------------
module mipsx_regfile (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [mipsx_pkg::GPR_AW-1:0]    rd_addr_a,
  input  logic [mipsx_pkg::GPR_AW-1:0]    rd_addr_b,
  output logic [mipsx_pkg::XLEN-1:0]      rd_data_a,
  output logic [mipsx_pkg::XLEN-1:0]      rd_data_b,
  input  mipsx_pkg::gpr_wr_t              wr
);
  import mipsx_pkg::*;

  logic [XLEN-1:0]    mem [GPR_NUM];
  logic [GPR_NUM-1:0] written;
  logic [XLEN-1:0]    mem_a;
  logic [XLEN-1:0]    mem_b;
  logic               vld_a;
  logic               vld_b;
  logic [GPR_AW-1:0]  addr_a;
  logic [GPR_AW-1:0]  addr_b;
  logic               last_vld;
  logic [GPR_AW-1:0]  last_addr;
  logic [XLEN-1:0]    last_data;
  logic               wr_ok;

  assign wr_ok = wr.en && (wr.addr != '0);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr.addr] <= wr.data;
    end
    mem_a  <= mem[rd_addr_a];
    mem_b  <= mem[rd_addr_b];
    addr_a <= rd_addr_a;
    addr_b <= rd_addr_b;
    if (wr_ok) begin
      last_addr <= wr.addr;
      last_data <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written  <= '0;
      vld_a    <= 1'b0;
      vld_b    <= 1'b0;
      last_vld <= 1'b0;
    end else begin
      vld_a <= written[rd_addr_a];
      vld_b <= written[rd_addr_b];
      if (wr_ok) begin
        written[wr.addr] <= 1'b1;
        last_vld         <= 1'b1;
      end
    end
  end

  always_comb begin
    if (last_vld && (last_addr == addr_a)) begin
      rd_data_a = last_data;
    end else begin
      rd_data_a = vld_a ? mem_a : '0;
    end
    if (last_vld && (last_addr == addr_b)) begin
      rd_data_b = last_data;
    end else begin
      rd_data_b = vld_b ? mem_b : '0;
    end
  end

endmodule

>>> hdl/mipsx_exec.sv
// ----------------------------------------------------------------------------
// mipsx_exec
// Decode and execute logic for one word: computes the result, the write
// to the register file and the next program counter, branch, load and
// halt state.
// ----------------------------------------------------------------------------
module mipsx_exec (
  input  logic                       func,
  input  logic [mipsx_pkg::XLEN-1:0] instr_word,
  input  logic [mipsx_pkg::XLEN-1:0] read_data,
  input  logic [mipsx_pkg::XLEN-1:0] vs,
  input  logic [mipsx_pkg::XLEN-1:0] vt,
  input  mipsx_pkg::arch_t           cur,
  output mipsx_pkg::arch_t           nxt,
  output mipsx_pkg::gpr_wr_t         wr,
  output mipsx_pkg::result_t         res
);
  import mipsx_pkg::*;

  logic [5:0]        op;
  logic [5:0]        fn;
  logic [GPR_AW-1:0] rt;
  logic [GPR_AW-1:0] rd;
  logic [4:0]        sa;
  logic [15:0]       imm;
  logic [XLEN-1:0]   simm;
  logic [XLEN-1:0]   ea;
  logic [XLEN-1:0]   seq_pc;
  logic              known;

  assign op     = instr_word[31:26];
  assign rt     = instr_word[20:16];
  assign rd     = instr_word[15:11];
  assign sa     = instr_word[10:6];
  assign fn     = instr_word[5:0];
  assign imm    = instr_word[15:0];
  assign simm   = {{(XLEN-16){imm[15]}}, imm};
  assign ea     = vs + simm;
  assign seq_pc = cur.fetch_pc + 32'd4;

  always_comb begin
    case (op)
      OP_SPECIAL: known = (fn == FN_SLL) || (fn == FN_ADDU);
      default:    known = op inside {OP_BNE, OP_ADDIU, OP_ORI, OP_LUI,
                                     OP_LW, OP_LBU, OP_SW};
    endcase
  end

  always_comb begin
    nxt        = cur;
    wr         = '0;
    res        = '0;
    res.status = ST_OK;
    if (cur.halted) begin
      res.status = ST_HALTED;
    end else if (func == FUNC_LOAD) begin
      if (!cur.load_pending) begin
        res.status = ST_REJECTED;
      end else begin
        wr.en            = 1'b1;
        wr.addr          = cur.load_dest;
        wr.data          = cur.load_is_byte ? {24'd0, read_data[7:0]} : read_data;
        nxt.load_pending = 1'b0;
      end
    end else if (cur.load_pending) begin
      res.status = ST_REJECTED;
    end else if (!known) begin
      res.status = ST_UNIMPL;
      nxt.halted = 1'b1;
    end else begin
      nxt.fetch_pc       = cur.branch_pending ? cur.branch_target : seq_pc;
      nxt.branch_pending = 1'b0;
      case (op)
        OP_SPECIAL: begin
          wr.en   = 1'b1;
          wr.addr = rd;
          wr.data = (fn == FN_SLL) ? (vt << sa) : (vs + vt);
        end
        OP_BNE: begin
          if (vs != vt) begin
            nxt.branch_target  = seq_pc + {simm[XLEN-3:0], 2'b00};
            nxt.branch_pending = 1'b1;
          end
        end
        OP_ADDIU: begin
          wr.en   = 1'b1;
          wr.addr = rt;
          wr.data = ea;
        end
        OP_ORI: begin
          wr.en   = 1'b1;
          wr.addr = rt;
          wr.data = vs | {16'd0, imm};
        end
        OP_LUI: begin
          wr.en   = 1'b1;
          wr.addr = rt;
          wr.data = {imm, 16'd0};
        end
        OP_LW, OP_LBU: begin
          res.mem_read     = 1'b1;
          res.mem_byte     = (op == OP_LBU);
          res.mem_address  = ea;
          nxt.load_pending = 1'b1;
          nxt.load_dest    = rt;
          nxt.load_is_byte = (op == OP_LBU);
        end
        OP_SW: begin
          res.mem_write   = 1'b1;
          res.mem_address = ea;
          res.store_data  = vt;
        end
        default: begin
        end
      endcase
    end
    if (wr.addr == '0) begin
      wr.en = 1'b0;
    end
    res.fetch_address = nxt.fetch_pc;
  end

endmodule

>>> hdl/mips_subset_instruction_execute.sv
// ----------------------------------------------------------------------------
// mips_subset_instruction_execute
// Words are registered into execute, results into the output register.
// Throughput: one word per cycle unless the output stalls; the register file
// read is the one stage in front of execute, and a write is forwarded to the
// word right behind it. Reset: control state and register valid bits clear at
// once, so every register reads zero and the fetch PC returns to 0xBFC00000.
// ----------------------------------------------------------------------------
module mips_subset_instruction_execute (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [mipsx_pkg::XLEN-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       func,
  input  logic [mipsx_pkg::XLEN-1:0] instr_word,
  input  logic [mipsx_pkg::XLEN-1:0] read_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [mipsx_pkg::XLEN-1:0] fetch_address,
  output logic                       mem_read,
  output logic                       mem_write,
  output logic                       mem_byte,
  output logic [mipsx_pkg::XLEN-1:0] mem_address,
  output logic [mipsx_pkg::XLEN-1:0] store_data,
  output logic [1:0]                 status
);
  import mipsx_pkg::*;

  logic              s1_valid;
  logic              s1_func;
  logic [XLEN-1:0]   s1_instr;
  logic [XLEN-1:0]   s1_rdata;
  logic              s1_adv;
  logic              s1_hold;
  logic              s1_fire;
  logic [GPR_AW-1:0] rd_addr_a;
  logic [GPR_AW-1:0] rd_addr_b;
  logic [XLEN-1:0]   vs;
  logic [XLEN-1:0]   vt;
  arch_t             arch;
  arch_t             arch_next;
  gpr_wr_t           gpr_wr;
  gpr_wr_t           rf_wr;
  result_t           res;
  result_t           res_q;

  assign s1_adv   = !out_valid || !out_stall;
  assign s1_hold  = s1_valid && !s1_adv;
  assign s1_fire  = s1_valid && s1_adv;
  assign in_stall = s1_hold;

  assign rd_addr_a = s1_hold ? s1_instr[25:21] : instr_word[25:21];
  assign rd_addr_b = s1_hold ? s1_instr[20:16] : instr_word[20:16];

  // The register file is written only when the word in execute moves on.
  always_comb begin
    rf_wr    = gpr_wr;
    rf_wr.en = gpr_wr.en && s1_fire;
  end

  mipsx_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (vs),
    .rd_data_b (vt),
    .wr        (rf_wr)
  );

  mipsx_exec u_exec (
    .func       (s1_func),
    .instr_word (s1_instr),
    .read_data  (s1_rdata),
    .vs         (vs),
    .vt         (vt),
    .cur        (arch),
    .nxt        (arch_next),
    .wr         (gpr_wr),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!s1_hold) begin
      s1_func  <= func;
      s1_instr <= instr_word;
      s1_rdata <= read_data;
    end
    if (s1_fire) begin
      res_q <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      arch      <= '{fetch_pc: BOOT_RESET, default: '0};
    end else begin
      if (!s1_hold) begin
        s1_valid <= in_valid;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        arch.fetch_pc <= cfg_wdata;
      end else if (s1_fire) begin
        arch <= arch_next;
      end
    end
  end

  assign fetch_address = res_q.fetch_address;
  assign mem_read      = res_q.mem_read;
  assign mem_write     = res_q.mem_write;
  assign mem_byte      = res_q.mem_byte;
  assign mem_address   = res_q.mem_address;
  assign store_data    = res_q.store_data;
  assign status        = res_q.status;

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    arch.halted |=> arch.halted)
    else $error("halt state cleared without reset");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with no word in the execute stage");

  a_load_sets_pending: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && res.mem_read && !cfg_we) |=> arch.load_pending)
    else $error("issued load did not mark a pending return");

  a_no_access_on_fault: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && (res.status != ST_OK)) |-> (!res.mem_read && !res.mem_write
      && !gpr_wr.en))
    else $error("faulting word caused a side effect");

endmodule
